@@ rtl/core/gkde_pkg.sv @@
// Shared types, codes and constant tables of the Gaussian KDE core.
// No dependencies; every other file of the core refers to it by scoped names.
package gkde_pkg;

   localparam int KIND_W     = 2;
   localparam int COORD_W    = 16;
   localparam int DENS_W     = 32;
   localparam int STAT_W     = 2;
   localparam int CNT_OUT_W  = 11;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam int D2_W       = 52;
   localparam int A_W        = D2_W - 9;

   localparam logic [30:0]    Q30_ONE  = 31'h4000_0000;
   localparam logic [A_W-1:0] KERN_CUT = A_W'(32'd786432);   // 12.0 in Q.16
   localparam logic [63:0]    U_LIMIT  = 64'h0000_0000_00FF_FFFF;
   localparam logic [47:0]    KRND     = 48'h0000_2000_0000;

   localparam logic [15:0] INV_BW_RST = 16'd256;
   localparam logic [31:0] NORM_RST   = 32'd65536;
   localparam logic [2:0]  DIMS_RST   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_INV_BW = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NORM   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DIMS   = 8'd2;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD  = 2'd0,
      KIND_QUERY = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic       take;
      logic       store_row;
      logic       clear_store;
      logic       d2_clear;
      logic       dim_mul;
      logic       dim_sq;
      logic       dim_acc;
      logic       kern_init;
      logic       hz_mul;
      logic       hz_rcp;
      logic       hz_fix;
      logic       kern_acc;
      logic       norm_lo;
      logic       norm_hi;
      logic       div_start;
      logic       div_step;
      logic       res_final;
      logic       rsp_load;
      logic [2:0] dim;
      logic [3:0] k;
   } dp_cmd_type;

   typedef struct packed {
      kind_type in_kind;
      logic     full;
      logic     empty;
      logic     last_dim;
      logic     last_sample;
      logic     div_last;
   } dp_stat_type;

   // round(exp(-n) * 65536)
   function automatic logic [16:0] exp_int(input logic [3:0] n);
      logic [16:0] v;
      case (n)
         4'd0:    v = 17'd65536;
         4'd1:    v = 17'd24109;
         4'd2:    v = 17'd8869;
         4'd3:    v = 17'd3263;
         4'd4:    v = 17'd1200;
         4'd5:    v = 17'd442;
         4'd6:    v = 17'd162;
         4'd7:    v = 17'd60;
         4'd8:    v = 17'd22;
         4'd9:    v = 17'd8;
         4'd10:   v = 17'd3;
         4'd11:   v = 17'd1;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   // floor(2^32 / k), with k = 1 held just below 2^32
   function automatic logic [31:0] recip(input logic [3:0] k);
      logic [31:0] v;
      case (k)
         4'd1:    v = 32'hFFFF_FFFF;
         4'd2:    v = 32'h8000_0000;
         4'd3:    v = 32'h5555_5555;
         4'd4:    v = 32'h4000_0000;
         4'd5:    v = 32'h3333_3333;
         4'd6:    v = 32'h2AAA_AAAA;
         4'd7:    v = 32'h2492_4924;
         4'd8:    v = 32'h2000_0000;
         default: v = 32'h0000_0000;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/core/gkde_req_if.sv @@
// Request channel of the Gaussian KDE core: valid/ready plus one item.
// Depends on gkde_pkg for field widths.
interface gkde_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [gkde_pkg::KIND_W-1:0]          kind;
   logic signed [gkde_pkg::COORD_W-1:0]  coord_0;
   logic signed [gkde_pkg::COORD_W-1:0]  coord_1;
   logic signed [gkde_pkg::COORD_W-1:0]  coord_2;
   logic signed [gkde_pkg::COORD_W-1:0]  coord_3;
   modport source (output valid, kind, coord_0, coord_1, coord_2, coord_3, input ready);
   modport sink   (input valid, kind, coord_0, coord_1, coord_2, coord_3, output ready);
endinterface

@@ rtl/core/gkde_rsp_if.sv @@
// Response channel of the Gaussian KDE core: valid/ready plus one result.
// Depends on gkde_pkg for field widths.
interface gkde_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [gkde_pkg::DENS_W-1:0]     density;
   logic [gkde_pkg::STAT_W-1:0]     status;
   logic [gkde_pkg::CNT_OUT_W-1:0]  stored_count;
   modport source (output valid, density, status, stored_count, input ready);
   modport sink   (input valid, density, status, stored_count, output ready);
endinterface

@@ rtl/core/gkde_csr_if.sv @@
// Register write channel of the Gaussian KDE core: valid/ready, index, data.
// Depends on gkde_pkg for field widths.
interface gkde_csr_if;
   logic                             valid;
   logic                             ready;
   logic [gkde_pkg::CSR_IDX_W-1:0]   index;
   logic [gkde_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/gaussian_kde_multivariate_core.sv @@
// Gaussian KDE core. Load and clear write or empty the store before the result; a
// dropped load, a query on an empty store and an unknown kind go straight to it.
// A query takes per sample one memory read, three steps per dimension and 8 Horner
// steps of multiply, reciprocal and fix, then a bit-serial divide by the count (59
// steps by default). One transaction at a time; a new request is taken while a
// result waits. Synchronous reset empties the store.
module gaussian_kde_multivariate_core #(
   parameter int DIMS        = 4,
   parameter int MAX_SAMPLES = 1024,
   parameter int COORD_BITS  = 16
) (
   input logic         clock,
   input logic         reset,
   gkde_req_if.sink    req_bus,
   gkde_rsp_if.source  rsp_bus,
   gkde_csr_if.sink    csr_bus
);

   gkde_pkg::dp_cmd_type  cmd;
   gkde_pkg::dp_stat_type stat;

   assign csr_bus.ready = 1'b1;

   gkde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gkde_datapath #(
      .DIMS        (DIMS),
      .MAX_SAMPLES (MAX_SAMPLES),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_bus.kind),
      .req_coord_0      (req_bus.coord_0),
      .req_coord_1      (req_bus.coord_1),
      .req_coord_2      (req_bus.coord_2),
      .req_coord_3      (req_bus.coord_3),
      .csr_we           (csr_bus.valid),
      .csr_index        (csr_bus.index),
      .csr_data         (csr_bus.data),
      .rsp_density      (rsp_bus.density),
      .rsp_status       (rsp_bus.status),
      .rsp_stored_count (rsp_bus.stored_count)
   );

endmodule

@@ rtl/core/gkde_ctrl.sv @@
// Sequencer of the Gaussian KDE core: walks samples, dimensions, Horner steps
// and divider steps. Depends on gkde_pkg for command and status types.
module gkde_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  gkde_pkg::dp_stat_type   stat,
   output gkde_pkg::dp_cmd_type    cmd
);

   typedef enum logic [17:0] {
      ST_IDLE  = 18'h00001,
      ST_LOAD  = 18'h00002,
      ST_CLEAR = 18'h00004,
      ST_RD    = 18'h00008,
      ST_MUL   = 18'h00010,
      ST_SQ    = 18'h00020,
      ST_ACC   = 18'h00040,
      ST_KINIT = 18'h00080,
      ST_HMUL  = 18'h00100,
      ST_HRCP  = 18'h00200,
      ST_HFIX  = 18'h00400,
      ST_KFIN  = 18'h00800,
      ST_NLO   = 18'h01000,
      ST_NHI   = 18'h02000,
      ST_DINIT = 18'h04000,
      ST_DSTEP = 18'h08000,
      ST_FINAL = 18'h10000,
      ST_DONE  = 18'h20000
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  dim_ff, dim_in;
   logic [3:0]  k_ff, k_in;
   logic        rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd       = '0;
      cmd.dim   = dim_ff;
      cmd.k     = k_ff;
      state_in  = state_ff;
      dim_in    = dim_ff;
      k_in      = k_ff;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (stat.in_kind == gkde_pkg::KIND_LOAD) begin
                  state_in = stat.full ? ST_DONE : ST_LOAD;
               end else if (stat.in_kind == gkde_pkg::KIND_QUERY) begin
                  state_in = stat.empty ? ST_DONE : ST_RD;
               end else if (stat.in_kind == gkde_pkg::KIND_CLEAR) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_LOAD: begin
            cmd.store_row = 1'b1;
            state_in      = ST_DONE;
         end
         ST_CLEAR: begin
            cmd.clear_store = 1'b1;
            state_in        = ST_DONE;
         end
         ST_RD: begin
            cmd.d2_clear = 1'b1;
            dim_in       = 3'd0;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.dim_mul = 1'b1;
            state_in    = ST_SQ;
         end
         ST_SQ: begin
            cmd.dim_sq = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.dim_acc = 1'b1;
            if (stat.last_dim) begin
               state_in = ST_KINIT;
            end else begin
               dim_in   = dim_ff + 3'd1;
               state_in = ST_MUL;
            end
         end
         ST_KINIT: begin
            cmd.kern_init = 1'b1;
            k_in          = 4'd8;
            state_in      = ST_HMUL;
         end
         ST_HMUL: begin
            cmd.hz_mul = 1'b1;
            state_in   = ST_HRCP;
         end
         ST_HRCP: begin
            cmd.hz_rcp = 1'b1;
            state_in   = ST_HFIX;
         end
         ST_HFIX: begin
            cmd.hz_fix = 1'b1;
            if (k_ff == 4'd1) begin
               state_in = ST_KFIN;
            end else begin
               k_in     = k_ff - 4'd1;
               state_in = ST_HMUL;
            end
         end
         ST_KFIN: begin
            cmd.kern_acc = 1'b1;
            state_in     = stat.last_sample ? ST_NLO : ST_RD;
         end
         ST_NLO: begin
            cmd.norm_lo = 1'b1;
            state_in    = ST_NHI;
         end
         ST_NHI: begin
            cmd.norm_hi = 1'b1;
            state_in    = ST_DINIT;
         end
         ST_DINIT: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DSTEP;
         end
         ST_DSTEP: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cmd.res_final = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dim_ff       <= 3'd0;
         k_ff         <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dim_ff       <= dim_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> (state_ff != ST_IDLE))
      else $error("accepted transaction did not start work");

   a_horner_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HFIX && k_ff == 4'd1) |=> (state_ff == ST_KFIN))
      else $error("Horner loop did not end after last step");

   a_dim_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && !stat.last_dim)
      |=> (state_ff == ST_MUL && dim_ff == $past(dim_ff) + 3'd1))
      else $error("dimension loop did not advance");

endmodule

@@ rtl/core/gkde_datapath.sv @@
// Datapath of the Gaussian KDE core: registers, sample memory, distance and
// kernel arithmetic, normalization and divider. Depends on gkde_pkg.
module gkde_datapath #(
   parameter int DIMS        = 4,
   parameter int MAX_SAMPLES = 1024,
   parameter int COORD_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gkde_pkg::dp_cmd_type                 cmd,
   output gkde_pkg::dp_stat_type                stat,
   input  logic [gkde_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [gkde_pkg::COORD_W-1:0]  req_coord_0,
   input  logic signed [gkde_pkg::COORD_W-1:0]  req_coord_1,
   input  logic signed [gkde_pkg::COORD_W-1:0]  req_coord_2,
   input  logic signed [gkde_pkg::COORD_W-1:0]  req_coord_3,
   input  logic                                 csr_we,
   input  logic [gkde_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gkde_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic [gkde_pkg::DENS_W-1:0]          rsp_density,
   output logic [gkde_pkg::STAT_W-1:0]          rsp_status,
   output logic [gkde_pkg::CNT_OUT_W-1:0]       rsp_stored_count
);

   localparam int ADDRW = $clog2(MAX_SAMPLES);
   localparam int CNTW  = $clog2(MAX_SAMPLES + 1);
   localparam int DW    = COORD_BITS + 1;
   localparam int PRW   = DW + 17;
   localparam int SUMW  = CNTW + 16;
   localparam int PW    = SUMW + 32;
   localparam int DCW   = $clog2(PW + 1);
   localparam int CB_IN = (COORD_BITS < gkde_pkg::COORD_W) ? COORD_BITS : gkde_pkg::COORD_W;
   localparam int ROWW  = DIMS * COORD_BITS;

   // configuration and control state
   logic [15:0]       inv_bw_ff;
   logic [31:0]       norm_ff;
   logic [2:0]        dims_ff;
   logic [CNTW-1:0]   count_ff, count_in;
   logic [ADDRW-1:0]  rd_addr_ff, rd_addr_in;
   logic [DCW-1:0]    div_cnt_ff, div_cnt_in;

   // payload
   logic signed [COORD_BITS-1:0] pt_in [DIMS];
   logic signed [COORD_BITS-1:0] pt_ff [DIMS];
   logic signed [COORD_BITS-1:0] row_lane [DIMS];
   logic [ROWW-1:0]              row_pack;
   logic [ROWW-1:0]              row_ff;
   logic [ROWW-1:0]              mem [MAX_SAMPLES];

   logic signed [PRW-1:0]        p_ff, p_in;
   logic [47:0]                  sq_ff, sq_in;
   logic [gkde_pkg::D2_W-1:0]    d2_ff;
   logic                         zero_ff;
   logic [3:0]                   n_ff;
   logic [29:0]                  f30_ff;
   logic [30:0]                  e_ff;
   logic [29:0]                  t_ff;
   logic [29:0]                  q0_ff;
   logic [SUMW-1:0]              sum_ff;
   logic [PW-1:0]                prod_ff;
   logic [CNTW-1:0]              rem_ff, rem_in;
   logic [PW-1:0]                quo_ff, quo_in;
   logic [gkde_pkg::DENS_W-1:0]  res_density_ff, res_density_in;
   gkde_pkg::status_type         res_status_ff, res_status_in;
   logic [gkde_pkg::DENS_W-1:0]  rsp_density_ff;
   gkde_pkg::status_type         rsp_status_ff;
   logic [gkde_pkg::CNT_OUT_W-1:0] rsp_count_ff;

   // combinational intermediates
   logic signed [COORD_BITS-1:0] pt_sel, row_sel;
   logic signed [DW-1:0]         diff;
   logic signed [63:0]           u_w;
   logic [63:0]                  u_mag;
   logic [gkde_pkg::A_W-1:0]     a_val;
   logic [60:0]                  hm;
   logic [61:0]                  rc;
   logic [33:0]                  qk, rr;
   logic [30:0]                  qq;
   logic [47:0]                  km;
   logic [16:0]                  kern;
   logic [CNTW:0]                rem_sh;
   logic                         div_ge;
   logic [PW-17:0]               q_res;
   logic [3:0]                   eff_dims;

   // lanes above the four request coordinates stay zero
   for (genvar gi = 0; gi < DIMS; gi++) begin : g_lane
      if (gi == 0) begin : g_c0
         assign pt_in[gi] = COORD_BITS'(req_coord_0[CB_IN-1:0]);
      end else if (gi == 1) begin : g_c1
         assign pt_in[gi] = COORD_BITS'(req_coord_1[CB_IN-1:0]);
      end else if (gi == 2) begin : g_c2
         assign pt_in[gi] = COORD_BITS'(req_coord_2[CB_IN-1:0]);
      end else if (gi == 3) begin : g_c3
         assign pt_in[gi] = COORD_BITS'(req_coord_3[CB_IN-1:0]);
      end else begin : g_cz
         assign pt_in[gi] = '0;
      end
      assign row_pack[gi*COORD_BITS +: COORD_BITS] = pt_ff[gi];
      assign row_lane[gi] = row_ff[gi*COORD_BITS +: COORD_BITS];
   end

   // sample memory, one registered read per cycle and at most one write alongside it
   always_ff @(posedge clock) begin
      if (cmd.store_row) begin
         mem[count_ff[ADDRW-1:0]] <= row_pack;
      end
      row_ff <= mem[rd_addr_ff];
   end

   always_comb begin
      if (dims_ff == 3'd0) begin
         eff_dims = 4'd1;
      end else if (4'(dims_ff) > 4'(DIMS)) begin
         eff_dims = 4'(DIMS);
      end else begin
         eff_dims = 4'(dims_ff);
      end
   end

   always_comb begin
      pt_sel  = '0;
      row_sel = '0;
      for (int i = 0; i < DIMS; i++) begin
         if (cmd.dim == 3'(i)) begin
            pt_sel  = pt_ff[i];
            row_sel = row_lane[i];
         end
      end
      diff = DW'(pt_sel) - DW'(row_sel);
      p_in = PRW'(diff) * PRW'($signed({1'b0, inv_bw_ff}));

      // floor shift, then clamp the magnitude to 24 bits
      u_w   = 64'(p_ff >>> 8);
      u_mag = u_w[63] ? (64'd0 - u_w) : u_w;
      if (u_mag > gkde_pkg::U_LIMIT) begin
         u_mag = gkde_pkg::U_LIMIT;
      end
      sq_in = 48'(u_mag[23:0]) * 48'(u_mag[23:0]);

      a_val = d2_ff[gkde_pkg::D2_W-1:9];

      hm = 61'(f30_ff) * 61'(e_ff);
      rc = 62'(t_ff) * 62'(gkde_pkg::recip(cmd.k));
      qk = 34'(q0_ff) * 34'(cmd.k);
      rr = 34'(t_ff) - qk;
      qq = 31'(q0_ff) + ((rr >= 34'(cmd.k)) ? 31'd1 : 31'd0);

      km   = 48'(gkde_pkg::exp_int(n_ff)) * 48'(e_ff) + gkde_pkg::KRND;
      kern = zero_ff ? 17'd0 : km[46:30];

      rem_sh = {rem_ff, quo_ff[PW-1]};
      div_ge = (rem_sh >= {1'b0, count_ff});
      q_res  = quo_ff[PW-1:16];
   end

   always_comb begin
      count_in       = count_ff;
      rd_addr_in     = rd_addr_ff;
      div_cnt_in     = div_cnt_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      res_density_in = res_density_ff;
      res_status_in  = res_status_ff;
      if (cmd.take) begin
         rd_addr_in     = '0;
         res_density_in = '0;
         if (req_kind == gkde_pkg::KIND_LOAD && stat.full) begin
            res_status_in = gkde_pkg::STAT_FULL;
         end else if (req_kind == gkde_pkg::KIND_QUERY && stat.empty) begin
            res_status_in = gkde_pkg::STAT_EMPTY;
         end else begin
            res_status_in = gkde_pkg::STAT_OK;
         end
      end
      if (cmd.store_row) begin
         count_in = count_ff + CNTW'(1);
      end
      if (cmd.clear_store) begin
         count_in = '0;
      end
      if (cmd.kern_acc) begin
         rd_addr_in = rd_addr_ff + ADDRW'(1);
      end
      if (cmd.div_start) begin
         div_cnt_in = DCW'(PW);
         rem_in     = '0;
         quo_in     = prod_ff;
      end
      if (cmd.div_step) begin
         div_cnt_in = div_cnt_ff - DCW'(1);
         rem_in     = div_ge ? CNTW'(rem_sh - {1'b0, count_ff}) : CNTW'(rem_sh);
         quo_in     = {quo_ff[PW-2:0], div_ge};
      end
      if (cmd.res_final) begin
         // saturate to Q16.16
         res_density_in = (|q_res[PW-17:32]) ? '1 : q_res[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_bw_ff     <= gkde_pkg::INV_BW_RST;
         norm_ff       <= gkde_pkg::NORM_RST;
         dims_ff       <= gkde_pkg::DIMS_RST;
         count_ff      <= '0;
         rd_addr_ff    <= '0;
         div_cnt_ff    <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               gkde_pkg::REG_INV_BW: inv_bw_ff <= csr_data[15:0];
               gkde_pkg::REG_NORM:   norm_ff   <= csr_data;
               gkde_pkg::REG_DIMS:   dims_ff   <= csr_data[2:0];
               default: ;
            endcase
         end
         count_ff   <= count_in;
         rd_addr_ff <= rd_addr_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         for (int i = 0; i < DIMS; i++) begin
            pt_ff[i] <= pt_in[i];
         end
         sum_ff <= '0;
      end
      if (cmd.dim_mul) begin
         p_ff <= p_in;
      end
      if (cmd.dim_sq) begin
         sq_ff <= sq_in;
      end
      if (cmd.d2_clear) begin
         d2_ff <= '0;
      end else if (cmd.dim_acc) begin
         d2_ff <= d2_ff + gkde_pkg::D2_W'(sq_ff);
      end
      if (cmd.kern_init) begin
         zero_ff <= (a_val >= gkde_pkg::KERN_CUT);
         n_ff    <= a_val[19:16];
         f30_ff  <= {a_val[15:0], 14'd0};
         e_ff    <= gkde_pkg::Q30_ONE;
      end
      if (cmd.hz_mul) begin
         t_ff <= hm[59:30];
      end
      if (cmd.hz_rcp) begin
         q0_ff <= rc[61:32];
      end
      if (cmd.hz_fix) begin
         e_ff <= gkde_pkg::Q30_ONE - qq;
      end
      if (cmd.kern_acc) begin
         sum_ff <= sum_ff + SUMW'(kern);
      end
      if (cmd.norm_lo) begin
         prod_ff <= PW'(sum_ff) * PW'(norm_ff[15:0]);
      end
      if (cmd.norm_hi) begin
         prod_ff <= prod_ff + ((PW'(sum_ff) * PW'(norm_ff[31:16])) << 16);
      end
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      res_density_ff <= res_density_in;
      res_status_ff  <= res_status_in;
      if (cmd.rsp_load) begin
         rsp_density_ff <= res_density_ff;
         rsp_status_ff  <= res_status_ff;
         rsp_count_ff   <= gkde_pkg::CNT_OUT_W'(count_ff);
      end
   end

   assign stat.in_kind     = gkde_pkg::kind_type'(req_kind);
   assign stat.full        = (count_ff == CNTW'(MAX_SAMPLES));
   assign stat.empty       = (count_ff == '0);
   assign stat.last_dim    = ((4'(cmd.dim) + 4'd1) == eff_dims);
   assign stat.last_sample = ((CNTW'(rd_addr_ff) + CNTW'(1)) == count_ff);
   assign stat.div_last    = (div_cnt_ff == DCW'(1));

   assign rsp_density      = rsp_density_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_stored_count = rsp_count_ff;

endmodule

@@ bench/tb_gaussian_kde_multivariate_core.sv @@
// Testbench for gaussian_kde_multivariate_core: drives loads, queries and clears, and
// checks every response against a scoreboard that predicts the density in fixed point.
// Depends on gkde_pkg and the request, response and register write interfaces.
`timescale 1ns / 100ps

module tb_gaussian_kde_multivariate_core;

   // register index past the end of the list, expected to be ignored
   localparam logic [gkde_pkg::CSR_IDX_W-1:0] CSR_IDX_SPARE = 8'd3;

   typedef struct {
      logic [gkde_pkg::DENS_W-1:0]    density;
      gkde_pkg::status_type           status;
      logic [gkde_pkg::CNT_OUT_W-1:0] stored_count;
   } density_rsp_type;

   class kde_scoreboard;
      localparam int ROWS = 1024;
      localparam int NDIM = 4;
      longint          rows [ROWS][NDIM];
      int              count;
      logic [15:0]     inv_bw;
      logic [31:0]     norm;
      logic [2:0]      dims;
      density_rsp_type pending_rsp [$];
      int              errors;

      function new();
         count  = 0;
         inv_bw = gkde_pkg::INV_BW_RST;
         norm   = gkde_pkg::NORM_RST;
         dims   = gkde_pkg::DIMS_RST;
         errors = 0;
      endfunction

      function void set_reg(logic [gkde_pkg::CSR_IDX_W-1:0] idx,
                            logic [gkde_pkg::CSR_DATA_W-1:0] val);
         if (idx == gkde_pkg::REG_INV_BW)
            inv_bw = val[15:0];
         else if (idx == gkde_pkg::REG_NORM)
            norm = val;
         else if (idx == gkde_pkg::REG_DIMS)
            dims = val[2:0];
      endfunction

      // exp(-d2/2) in Q.16: integer part from the table, fraction by Horner
      function longint unsigned kernel_q16(longint unsigned d2);
         longint unsigned a, n, f30, e, t;
         a = d2 >> 9;
         if (a >= (64'd12 << 16))
            return 0;
         n   = a >> 16;
         f30 = (a & 64'hFFFF) << 14;
         e   = 64'd1 << 30;
         for (int k = 8; k >= 1; k--)
            e = (64'd1 << 30) - ((f30 * e) >> 30) / k;
         t = exp_int_tab(n);
         return (t * e + (64'd1 << 29)) >> 30;
      endfunction

      function longint unsigned exp_int_tab(longint unsigned n);
         longint unsigned tab [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                       22, 8, 3, 1};
         return tab[n];
      endfunction

      function void note_item(gkde_pkg::kind_type kind, logic signed [15:0] c [NDIM]);
         density_rsp_type r;
         longint       pt [NDIM];
         int           d;
         longint       diff, p, u;
         longint unsigned d2, sum, q;
         for (int i = 0; i < NDIM; i++)
            pt[i] = longint'(c[i]);
         r.density = '0;
         r.status  = gkde_pkg::STAT_OK;
         case (kind)
            gkde_pkg::KIND_LOAD: begin
               if (count < ROWS) begin
                  for (int i = 0; i < NDIM; i++)
                     rows[count][i] = pt[i];
                  count++;
               end else begin
                  r.status = gkde_pkg::STAT_FULL;
               end
            end
            gkde_pkg::KIND_QUERY: begin
               if (count == 0) begin
                  r.status = gkde_pkg::STAT_EMPTY;
               end else begin
                  d = (dims == 0) ? 1 : (dims > NDIM) ? NDIM : dims;
                  sum = 0;
                  for (int s = 0; s < count; s++) begin
                     d2 = 0;
                     for (int i = 0; i < d; i++) begin
                        diff = pt[i] - rows[s][i];
                        p = diff * longint'({48'd0, inv_bw});
                        u = p >>> 8;
                        if (u > 64'sd16777215) u = 64'sd16777215;
                        if (u < -64'sd16777215) u = -64'sd16777215;
                        d2 += longint'(u * u);
                     end
                     sum += kernel_q16(d2);
                  end
                  q = ((sum * {32'd0, norm}) / count) >> 16;
                  r.density = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
               end
            end
            gkde_pkg::KIND_CLEAR: count = 0;
            default: ;
         endcase
         r.stored_count = count[gkde_pkg::CNT_OUT_W-1:0];
         pending_rsp.push_back(r);
      endfunction

      function void check_rsp(logic [gkde_pkg::DENS_W-1:0] dens,
                              logic [gkde_pkg::STAT_W-1:0] stat,
                              logic [gkde_pkg::CNT_OUT_W-1:0] cnt);
         density_rsp_type e;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response density %h status %0d count %0d",
                     $realtime, dens, stat, cnt);
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         if (dens !== e.density) begin
            $display("%0t: density expected %h actual %h", $realtime, e.density, dens);
            errors++;
         end
         if (stat !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, e.status, stat);
            errors++;
         end
         if (cnt !== e.stored_count) begin
            $display("%0t: stored_count expected %0d actual %0d", $realtime,
                     e.stored_count, cnt);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   gkde_req_if req ();
   gkde_rsp_if rsp ();
   gkde_csr_if csr ();

   kde_scoreboard sb;
   int send_idle;
   int recv_idle;
   int hold_cycles;

   gaussian_kde_multivariate_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp),
      .csr_bus (csr)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   task automatic send_item(gkde_pkg::kind_type kind, logic signed [15:0] c [4]);
      bit gap;
      do begin
         @(negedge clock);
         gap = ($urandom_range(99) < send_idle);
         if (gap)
            req.valid = 1'b0;
      end while (gap);
      req.valid   = 1'b1;
      req.kind    = kind;
      req.coord_0 = c[0];
      req.coord_1 = c[1];
      req.coord_2 = c[2];
      req.coord_3 = c[3];
      do
         @(posedge clock);
      while (!req.ready);
      sb.note_item(kind, c);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req.valid = 1'b0;
      while (sb.pending_rsp.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(logic [gkde_pkg::CSR_IDX_W-1:0] idx,
                            logic [gkde_pkg::CSR_DATA_W-1:0] val);
      wait_drained();
      csr.valid = 1'b1;
      csr.index = idx;
      csr.data  = val;
      do
         @(posedge clock);
      while (!csr.ready);
      sb.set_reg(idx, val);
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   task automatic set_config(logic [15:0] bw, logic [31:0] nrm, logic [2:0] d);
      write_reg(gkde_pkg::REG_INV_BW, {16'd0, bw});
      write_reg(gkde_pkg::REG_NORM, nrm);
      write_reg(gkde_pkg::REG_DIMS, {29'd0, d});
   endtask

   function automatic logic signed [15:0] rand_coord();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(4096)) - 2048);
         2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         default: return 16'($signed($urandom_range(128)) - 64);
      endcase
   endfunction

   task automatic send_random();
      logic signed [15:0] c [4];
      gkde_pkg::kind_type k;
      int r;
      for (int i = 0; i < 4; i++)
         c[i] = rand_coord();
      r = $urandom_range(99);
      if (sb.count > 20 && r < 30)
         k = gkde_pkg::KIND_CLEAR;
      else if (r < 50)
         k = gkde_pkg::KIND_LOAD;
      else if (r < 88)
         k = gkde_pkg::KIND_QUERY;
      else if (r < 95)
         k = gkde_pkg::KIND_CLEAR;
      else
         k = gkde_pkg::KIND_NONE;
      send_item(k, c);
   endtask

   // response side: random backpressure plus one long hold-off
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp.ready = 1'b0;
         end else begin
            rsp.ready = ($urandom_range(99) >= recv_idle);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready)
            sb.check_rsp(rsp.density, rsp.status, rsp.stored_count);
      end
   end

   initial begin
      #100_000_000;
      $display("tb_gaussian_kde_multivariate_core NOT OK");
      $finish;
   end

   initial begin
      logic signed [15:0] c [4];
      sb          = new();
      send_idle   = 0;
      recv_idle   = 0;
      hold_cycles = 0;
      reset       = 1'b1;
      req.valid   = 1'b0;
      req.kind    = gkde_pkg::KIND_LOAD;
      req.coord_0 = '0;
      req.coord_1 = '0;
      req.coord_2 = '0;
      req.coord_3 = '0;
      csr.valid   = 1'b0;
      csr.index   = '0;
      csr.data    = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // directed: empty query, extremes, exact hit, unknown kind, clear, register settings, spare index
      c = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
      send_item(gkde_pkg::KIND_QUERY, c);
      send_item(gkde_pkg::KIND_NONE, c);
      send_item(gkde_pkg::KIND_LOAD, c);
      send_item(gkde_pkg::KIND_QUERY, c);
      c = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000};
      send_item(gkde_pkg::KIND_LOAD, c);
      send_item(gkde_pkg::KIND_QUERY, c);
      c = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
      send_item(gkde_pkg::KIND_QUERY, c);
      c = '{16'sh0100, 16'shFF00, 16'sh0080, 16'sh0000};
      send_item(gkde_pkg::KIND_QUERY, c);
      send_item(gkde_pkg::KIND_NONE, c);
      wait_drained();
      send_item(gkde_pkg::KIND_CLEAR, c);
      send_item(gkde_pkg::KIND_QUERY, c);
      set_config(16'd65535, 32'hFFFF_FFFF, 3'd0);
      write_reg(CSR_IDX_SPARE, 32'hDEAD_BEEF);
      c = '{16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000};
      send_item(gkde_pkg::KIND_LOAD, c);
      c = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
      send_item(gkde_pkg::KIND_LOAD, c);
      send_item(gkde_pkg::KIND_QUERY, c);
      set_config(16'd1, 32'd0, 3'd7);
      send_item(gkde_pkg::KIND_QUERY, c);
      c = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
      send_item(gkde_pkg::KIND_QUERY, c);
      set_config(16'd1, 32'hFFFF_FFFF, 3'd1);
      send_item(gkde_pkg::KIND_QUERY, c);
      send_item(gkde_pkg::KIND_CLEAR, c);

      // random phases over several register settings and idle patterns
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_config(gkde_pkg::INV_BW_RST, gkde_pkg::NORM_RST, gkde_pkg::DIMS_RST);
            1: set_config(16'd4096, 32'd1_000_000, 3'd2);
            2: set_config(16'd128, 32'hFFFF_FFFF, 3'd3);
            3: set_config(16'd65535, 32'd65536, 3'd4);
            4: set_config(16'd1, 32'd0, 3'd1);
            default: set_config(16'd700, 32'h0040_0000, 3'd5);
         endcase
         if (ph < 2) begin
            send_idle = 29;
            recv_idle = 88;
         end else if (ph < 4) begin
            send_idle = 88;
            recv_idle = 29;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         if (ph == 4)
            hold_cycles = 2000;
         for (int n = 0; n < 95; n++)
            send_random();
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0)
         $display("tb_gaussian_kde_multivariate_core OK");
      else
         $display("tb_gaussian_kde_multivariate_core NOT OK");
      $finish;
   end

endmodule
